/* sv/sha1_pkg.sv */
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types and constants of the sha-1 hash engine
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

   // one 512-bit message block, word 0 first (big-endian words)
   typedef logic [15:0][31:0] sha1_block_type;

   // five-word chaining value, word 0 is the most significant digest word
   typedef logic [4:0][31:0] sha1_chain_type;

   // control from the sequencer to the round unit
   typedef struct packed {
      logic start;   // load block and chaining value, run 80 rounds
      logic init;    // return chaining value to the initial vector
   } sha1_ctrl_type;

   localparam logic [31:0] IV_0 = 32'h67452301;
   localparam logic [31:0] IV_1 = 32'hEFCDAB89;
   localparam logic [31:0] IV_2 = 32'h98BADCFE;
   localparam logic [31:0] IV_3 = 32'h10325476;
   localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

   localparam sha1_chain_type INIT_VECTOR = {IV_4, IV_3, IV_2, IV_1, IV_0};

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam int unsigned ROUNDS = 80;
   localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

   // bytes per block that may hold data before the length words
   localparam logic [5:0] LEN_START = 6'd56;

   localparam logic [5:0] BLOCK_LAST_BYTE = 6'd63;

   // index of the last digest word of a message
   localparam logic [2:0] LAST_WORD = 3'd4;

endpackage

`default_nettype wire

/* sv/sha1_core.sv */
// ----------------------------------------------------------------------------
// sha1_core
// one round per cycle compression unit with chaining value and schedule
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sha1_pkg::sha1_ctrl_type ctrl,
   input  wire sha1_pkg::sha1_block_type blk,
   output logic                         done,
   output sha1_pkg::sha1_chain_type     chain
);

   sha1_pkg::sha1_chain_type chain_ff, chain_in;
   sha1_pkg::sha1_block_type w_ff, w_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic        run_ff, run_in;
   logic        add_ff, add_in;

   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;
   logic [31:0] w_mix;

   // round function and constant by round group
   always_comb begin
      if (rnd_ff < 7'd20) begin
         f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         k_val = sha1_pkg::K_0;
      end else if (rnd_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1_pkg::K_1;
      end else if (rnd_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (d_ff & (b_ff | c_ff));
         k_val = sha1_pkg::K_2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1_pkg::K_3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];

   // schedule window holds w[r] .. w[r+15]
   assign w_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];

   always_comb begin
      chain_in = chain_ff;
      w_in     = w_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      rnd_in   = rnd_ff;
      run_in   = run_ff;
      add_in   = 1'b0;

      if (ctrl.start) begin
         w_in   = blk;
         a_in   = chain_ff[0];
         b_in   = chain_ff[1];
         c_in   = chain_ff[2];
         d_in   = chain_ff[3];
         e_in   = chain_ff[4];
         rnd_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         a_in      = t_val;
         b_in      = a_ff;
         c_in      = {b_ff[1:0], b_ff[31:2]};
         d_in      = c_ff;
         e_in      = d_ff;
         w_in[14:0] = w_ff[15:1];
         w_in[15]   = {w_mix[30:0], w_mix[31]};
         rnd_in    = rnd_ff + 7'd1;
         if (rnd_ff == sha1_pkg::LAST_ROUND) begin
            run_in = 1'b0;
            add_in = 1'b1;
         end
      end

      // fold working variables into the chaining value
      if (add_ff) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end

      if (ctrl.init) begin
         chain_in = sha1_pkg::INIT_VECTOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha1_pkg::INIT_VECTOR;
         run_ff   <= 1'b0;
         add_ff   <= 1'b0;
         rnd_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         run_ff   <= run_in;
         add_ff   <= add_in;
         rnd_ff   <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   assign done  = add_ff;
   assign chain = chain_ff;

endmodule

`default_nettype wire

/* sv/sha1_hash_engine.sv */
// a byte that does not close a block leaves the request side ready; a byte that closes a
//   block then holds the request side through load, 80 rounds and fold
// a last request holds it through pad, load, 80 rounds, fold and done, and through a
//   second block when one is needed; words follow in the cycle after done, one per
//   cycle while rsp_tready is high; no new byte is taken while a block is compressed
// reset: synchronous, active high; chaining value returns to the initial vector
// ----------------------------------------------------------------------------
// sha1_hash_engine
// streaming sha-1 hasher: byte packing, padding, length and digest output
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] has_byte
   input  wire logic        req_tlast,   // last request of the message
   // digest channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] digest_word
   output logic [2:0]       rsp_tuser,   // [2:0] word_index
   output logic             rsp_tlast    // final_word
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;   // taking requests
   localparam logic [2:0] ST_PAD  = 3'd1;   // build the padded block
   localparam logic [2:0] ST_LOAD = 3'd2;   // hand block to the round unit
   localparam logic [2:0] ST_RUN  = 3'd3;   // rounds in progress
   localparam logic [2:0] ST_DONE = 3'd4;   // move digest to the output buffer

   // what the block in flight is
   localparam logic [1:0] KIND_DATA  = 2'd0;   // full block of message bytes
   localparam logic [1:0] KIND_PADX  = 2'd1;   // padded, length follows in next block
   localparam logic [1:0] KIND_FINAL = 2'd2;   // carries the length

   logic [2:0]  state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic        last_ff, last_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   sha1_pkg::sha1_block_type msg_ff, msg_in;

   // output buffer, shifts one word per response
   sha1_pkg::sha1_chain_type dig_ff, dig_in;
   logic [2:0]  idx_ff, idx_in;
   logic        busy_ff, busy_in;

   sha1_pkg::sha1_ctrl_type  core_ctrl;
   sha1_pkg::sha1_chain_type core_chain;
   logic                     core_done;

   logic                     req_accept;
   logic                     rsp_accept;
   logic [63:0]              bit_len;
   logic [4:0]               lane_sh;
   sha1_pkg::sha1_block_type pad_blk;
   sha1_pkg::sha1_block_type len_blk;

   assign req_accept = req_tvalid & req_tready;
   assign rsp_accept = rsp_tvalid & rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // message length in bits, wraps modulo 2^64
   assign bit_len = {count_ff, 3'b000};

   // big-endian byte lane of the next byte inside its word
   assign lane_sh = {~fill_ff[1:0], 3'b000};

   // held bytes, then 0x80, then zeros
   always_comb begin
      for (int p = 0; p < 64; p++) begin
         if (6'(p) < fill_ff) begin
            pad_blk[p >> 2][(8 * (3 - (p & 3))) +: 8] = msg_ff[p >> 2][(8 * (3 - (p & 3))) +: 8];
         end else if (6'(p) == fill_ff) begin
            pad_blk[p >> 2][(8 * (3 - (p & 3))) +: 8] = sha1_pkg::PAD_BYTE;
         end else begin
            pad_blk[p >> 2][(8 * (3 - (p & 3))) +: 8] = 8'h00;
         end
      end
   end

   // extra block of zeros with the length
   always_comb begin
      len_blk     = '0;
      len_blk[14] = bit_len[63:32];
      len_blk[15] = bit_len[31:0];
   end

   // main sequencer
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      last_in   = last_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      msg_in    = msg_ff;
      core_ctrl = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               last_in = req_tlast;
               if (req_tuser) begin
                  msg_in[fill_ff[5:2]][lane_sh +: 8] = req_tdata;
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + 61'd1;
               end
               if (req_tuser && (fill_ff == sha1_pkg::BLOCK_LAST_BYTE)) begin
                  // block full: compress before anything else
                  kind_in  = KIND_DATA;
                  state_in = ST_LOAD;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            msg_in = pad_blk;
            if (fill_ff >= sha1_pkg::LEN_START) begin
               // no room for the length words
               kind_in = KIND_PADX;
            end else begin
               msg_in[14] = bit_len[63:32];
               msg_in[15] = bit_len[31:0];
               kind_in    = KIND_FINAL;
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            core_ctrl.start = 1'b1;
            state_in        = ST_RUN;
         end
         ST_RUN: begin
            if (core_done) begin
               case (kind_ff)
                  KIND_DATA: begin
                     state_in = last_ff ? ST_PAD : ST_IDLE;
                  end
                  KIND_PADX: begin
                     msg_in   = len_blk;
                     kind_in  = KIND_FINAL;
                     state_in = ST_LOAD;
                  end
                  KIND_FINAL: begin
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            // wait until the previous digest has drained
            if (!busy_ff) begin
               core_ctrl.init = 1'b1;
               fill_in        = '0;
               count_in       = '0;
               last_in        = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // digest output buffer
   always_comb begin
      dig_in  = dig_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (rsp_accept) begin
         dig_in[3:0] = dig_ff[4:1];
         dig_in[4]   = '0;
         idx_in      = idx_ff + 3'd1;
         if (idx_ff == sha1_pkg::LAST_WORD) begin
            busy_in = 1'b0;
         end
      end
      if ((state_ff == ST_DONE) && !busy_ff) begin
         dig_in  = core_chain;
         idx_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_DATA;
         last_ff  <= 1'b0;
         fill_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         busy_ff  <= 1'b0;
         msg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         last_ff  <= last_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         busy_ff  <= busy_in;
         msg_ff   <= msg_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
   end

   sha1_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (core_ctrl),
      .blk   (msg_ff),
      .done  (core_done),
      .chain (core_chain)
   );

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = dig_ff[0];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == sha1_pkg::LAST_WORD);

endmodule

`default_nettype wire

/* sv/sha1_checker.sv */
// ----------------------------------------------------------------------------
// sha1_checker
// port-level checks of the digest channel of the hash engine
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // no digest word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("digest valid right after reset");

   // final word flag goes with the fifth word only
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == sha1_pkg::LAST_WORD)))
      else $error("final word flag does not match word index");

   // words come in order with no gap inside a digest
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == 3'($past(rsp_tuser) + 3'd1)))
      else $error("digest word skipped or out of order");

   // a new digest starts at word 0
   a_index_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (rsp_tuser == 3'd0))
      else $error("digest does not start at word 0");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled digest word changed");

endmodule

bind sha1_hash_engine sha1_checker u_checker (.*);

`default_nettype wire

/* sim/sha1_hash_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_hash_engine_tb
// self-checking bench: message bytes are streamed in with random gaps, each
// digest is computed by an in-bench sha-1 model and compared word by word
// ----------------------------------------------------------------------------

module sha1_hash_engine_tb;

   localparam int unsigned CLOCK_HALF      = 4;
   localparam int unsigned RESET_CYCLES    = 6;
   localparam int unsigned RSP_HOLD_CYCLES = 1500;
   localparam int unsigned DRAIN_CYCLES    = 200;
   localparam int unsigned TIMEOUT_CYCLES  = 200000;
   localparam int unsigned TOTAL_ITEMS     = 150;
   localparam int unsigned MAX_REPORTS     = 10;

   // sha-1 initial chaining value and round constants
   localparam bit [31:0] H_INIT_0 = 32'h67452301;
   localparam bit [31:0] H_INIT_1 = 32'hEFCDAB89;
   localparam bit [31:0] H_INIT_2 = 32'h98BADCFE;
   localparam bit [31:0] H_INIT_3 = 32'h10325476;
   localparam bit [31:0] H_INIT_4 = 32'hC3D2E1F0;
   localparam bit [31:0] ROUND_K_0 = 32'h5A827999;
   localparam bit [31:0] ROUND_K_1 = 32'h6ED9EBA1;
   localparam bit [31:0] ROUND_K_2 = 32'h8F1BBCDC;
   localparam bit [31:0] ROUND_K_3 = 32'hCA62C1D6;
   localparam bit [7:0]  PAD_MARK  = 8'h80;
   localparam int unsigned LEN_SLOT   = 56;
   localparam int unsigned BLOCK_SIZE = 64;
   localparam int unsigned DIGEST_WORDS = 5;

   typedef struct packed {
      bit [7:0] data_byte;
      bit       has_byte;
      bit       is_end;
   } req_item_type;

   typedef struct packed {
      bit [31:0] digest_word;
      bit [2:0]  word_index;
      bit        final_word;
   } digest_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] has_byte
   logic        req_tlast = 1'b0;    // last request of the message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [31:0] digest_word
   logic [2:0]  rsp_tuser;           // [2:0] word_index
   logic        rsp_tlast;           // final_word

   sha1_hash_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLOCK_HALF) clock = ~clock;

   initial begin : reset_gen
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // digest model: chaining value, partial block, fill position, length
   // ------------------------------------------------------------------------
   bit [31:0] chain [DIGEST_WORDS];
   bit [31:0] msg_block [16];
   bit [5:0]  fill_pos;
   bit [60:0] msg_len;

   digest_entry_type digest_expected [$];

   function automatic bit [31:0] rotl(bit [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void digest_clear();
      chain[0] = H_INIT_0;
      chain[1] = H_INIT_1;
      chain[2] = H_INIT_2;
      chain[3] = H_INIT_3;
      chain[4] = H_INIT_4;
      foreach (msg_block[i]) msg_block[i] = '0;
      fill_pos = '0;
      msg_len  = '0;
   endfunction

   // big-endian byte placement within the 16-word block
   function automatic void block_put(int unsigned pos, bit [7:0] v);
      msg_block[pos / 4][8 * (3 - pos % 4) +: 8] = v;
   endfunction

   // 80 rounds over the current block, folded into the chaining value
   function automatic void block_compress();
      bit [31:0] w [16];
      bit [31:0] a, b, c, d, e, f, k, wr, t;
      w = msg_block;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
         if (r >= 16) begin
            wr = rotl(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15], 1);
            w[r & 15] = wr;
         end else begin
            wr = w[r];
         end
         if (r < 20) begin
            f = d ^ (b & (c ^ d));
            k = ROUND_K_0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = ROUND_K_1;
         end else if (r < 60) begin
            f = (b & c) | (d & (b | c));
            k = ROUND_K_2;
         end else begin
            f = b ^ c ^ d;
            k = ROUND_K_3;
         end
         t = rotl(a, 5) + f + e + k + wr;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   // one accepted request; a message end queues the five digest words
   function automatic void digest_absorb(bit [7:0] data_in, bit has_byte, bit is_end);
      bit [63:0]        bit_len;
      digest_entry_type ent;
      if (has_byte) begin
         block_put(fill_pos, data_in);
         fill_pos++;
         msg_len++;
         if (fill_pos == 0) block_compress();
      end
      if (is_end) begin
         bit_len = {msg_len, 3'b000};
         block_put(fill_pos, PAD_MARK);
         for (int p = int'(fill_pos) + 1; p < BLOCK_SIZE; p++) block_put(p, 8'h00);
         // no room for the length: spill into an extra block
         if (fill_pos >= LEN_SLOT) begin
            block_compress();
            foreach (msg_block[i]) msg_block[i] = '0;
         end
         msg_block[14] = bit_len[63:32];
         msg_block[15] = bit_len[31:0];
         block_compress();
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            ent.digest_word = chain[i];
            ent.word_index  = 3'(i);
            ent.final_word  = (i == DIGEST_WORDS - 1);
            digest_expected.push_back(ent);
         end
         digest_clear();
      end
   endfunction

   // ------------------------------------------------------------------------
   // shared bookkeeping
   // ------------------------------------------------------------------------
   req_item_type req_pending [$];
   int unsigned items_total;     // everything queued, idle requests included
   int unsigned items_data;      // requests that carry a byte or end a message
   int unsigned items_taken;
   int unsigned msgs_queued;
   int unsigned msg_bytes;
   int unsigned longest_msg;
   int unsigned words_seen;
   int unsigned mismatches;

   bit          req_fire;
   bit          req_busy;
   int          req_gap;
   int          req_burst;
   bit          rsp_fire;
   bit          rsp_valid_seen;
   bit          rsp_hold;
   int          rsp_stall;
   int          rsp_burst;

   // wait length per request or result; sometimes a run of back-to-back ones
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 4);
   endfunction

   task automatic flag_mismatch(string what, bit [31:0] want, bit [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at %0t: %s, expected 0x%08h, got 0x%08h", $realtime, what, want,
                  got);
   endtask

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // drive on the falling edge, one new request at a time
   always @(negedge clock) begin : req_driver
      req_item_type nxt;
      bit           offer;
      if (!reset) begin
         if (req_fire) begin
            req_fire = 1'b0;
            req_busy = 1'b0;
            req_gap  = draw_gap(req_burst);
         end
         if (!req_busy) begin
            offer = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (req_pending.size() > 0) begin
               nxt = req_pending.pop_front();
               req_tdata <= nxt.data_byte;
               req_tuser <= nxt.has_byte;
               req_tlast <= nxt.is_end;
               offer    = 1'b1;
               req_busy = 1'b1;
            end
            req_tvalid <= offer;
         end
      end
   end

   // acceptance is seen on the rising edge and fed straight to the model
   always @(posedge clock) begin : req_monitor
      if (!reset && req_tvalid && req_tready) begin
         req_fire = 1'b1;
         items_taken++;
         digest_absorb(req_tdata, req_tuser, req_tlast);
      end
   end

   // ------------------------------------------------------------------------
   // digest side
   // ------------------------------------------------------------------------

   // stall counts down only while a word is waiting, so it lands on any word
   always @(negedge clock) begin : rsp_driver
      if (!reset) begin
         if (rsp_fire) begin
            rsp_fire  = 1'b0;
            rsp_stall = draw_gap(rsp_burst);
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            if (rsp_valid_seen) rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      digest_entry_type want;
      if (!reset) begin
         rsp_valid_seen = rsp_tvalid;
         if (rsp_tvalid && rsp_tready) begin
            rsp_fire = 1'b1;
            words_seen++;
            if (digest_expected.size() == 0) begin
               flag_mismatch("digest word with none outstanding", '0, rsp_tdata);
            end else begin
               want = digest_expected.pop_front();
               if (rsp_tdata !== want.digest_word)
                  flag_mismatch("digest_word", want.digest_word, rsp_tdata);
               if (rsp_tuser !== want.word_index)
                  flag_mismatch("word_index", 32'(want.word_index), 32'(rsp_tuser));
               if (rsp_tlast !== want.final_word)
                  flag_mismatch("final_word", 32'(want.final_word), 32'(rsp_tlast));
            end
         end
      end
   end

   // long receiver stall with messages still streaming in, so the engine
   // backs up and stops taking bytes
   initial begin : rsp_hold_off
      rsp_hold = 1'b0;
      while (reset || items_taken < 40) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic push_req(bit [7:0] data_in, bit has_byte, bit is_end);
      req_item_type it;
      it.data_byte = data_in;
      it.has_byte  = has_byte;
      it.is_end    = is_end;
      req_pending.push_back(it);
      items_total++;
      if (has_byte || is_end) items_data++;
      if (has_byte) msg_bytes++;
      if (is_end) begin
         msgs_queued++;
         if (msg_bytes > longest_msg) longest_msg = msg_bytes;
         msg_bytes = 0;
      end
   endtask

   // random content, scattered idle requests, sometimes a byteless end request
   task automatic push_message(int unsigned len);
      bit empty_tail;
      empty_tail = (len == 0) || ($urandom_range(0, 4) == 0);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         push_req(8'($urandom_range(0, 255)), 1'b1, !empty_tail && (i == len - 1));
      end
      if (empty_tail) push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin : stimulus
      int unsigned boundary_lens [2];
      // padding spills at 56 bytes, last byte closes a block at 64
      boundary_lens = '{56, 64};
      digest_clear();

      // empty message, data bits ignored
      push_req(8'h5A, 1'b0, 1'b1);
      // single zero byte
      push_req(8'h00, 1'b1, 1'b1);
      // "abc"
      push_req(8'h61, 1'b1, 1'b0);
      push_req(8'h62, 1'b1, 1'b0);
      push_req(8'h63, 1'b1, 1'b1);
      // all-ones byte, an idle request, then a byteless end
      push_req(8'hFF, 1'b1, 1'b0);
      push_req(8'hA5, 1'b0, 1'b0);
      push_req(8'h3C, 1'b0, 1'b1);
      // single-bit and near-extreme bytes
      push_req(8'h80, 1'b1, 1'b0);
      push_req(8'h7F, 1'b1, 1'b0);
      push_req(8'h01, 1'b1, 1'b0);
      push_req(8'hFE, 1'b1, 1'b1);
      // back-to-back empty message
      push_req(8'hC3, 1'b0, 1'b1);

      // lengths right at the padding and block edges first
      foreach (boundary_lens[i]) push_message(boundary_lens[i]);
      // short random messages fill up the rest
      while (items_total < TOTAL_ITEMS) push_message($urandom_range(0, 12));

      while (items_taken < items_total) @(posedge clock);
      while (digest_expected.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d messages in %0d requests, longest %0d bytes, with empty,",
               msgs_queued, items_total, longest_msg);
      $display("  padding-spill and block-edge lengths; %0d digest words checked",
               words_seen);
      if (digest_expected.size() > 0)
         $display("%0d digest words never arrived", digest_expected.size());
      if (mismatches == 0 && digest_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(2 * CLOCK_HALF * TIMEOUT_CYCLES);
      $display("timeout: %0d of %0d requests taken, %0d digest words outstanding",
               items_taken, items_total, digest_expected.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
